/* hdl/bawm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bawm_pkg
// Shared types and constants for the approximate bitap window matcher.
// ----------------------------------------------------------------------------
package bawm_pkg;

  localparam int unsigned CODE_W     = 4;
  localparam logic [CODE_W-1:0] ANY_CODE = 4'hF;

  localparam int unsigned LEN_W      = 5;
  localparam int unsigned LIMIT_W    = 3;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned SEEN_W     = 6;
  localparam logic [SEEN_W-1:0] SEEN_MAX = 6'd63;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CODES_LO_W = 64;
  localparam int unsigned CODES_HI_W = 60;
  localparam int unsigned CFG_IDX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CODES_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODES_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_LIMIT  = 2'd3;

  localparam int unsigned DEF_MAX_PATTERN = 31;
  localparam int unsigned DEF_MAX_ERRORS  = 7;

  typedef struct packed {
    logic restart;
    logic advance;
  } cell_ctrl_t;

  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] error_count;
  } result_t;

endpackage

/* hdl/bawm_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bawm_in_if
// Symbol request channel: one base code with window flags.
// ----------------------------------------------------------------------------
interface bawm_in_if import bawm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] base_code;
  logic              window_start;
  logic              window_end;

  modport source (output valid, base_code, window_start, window_end, input ready);
  modport sink   (input valid, base_code, window_start, window_end, output ready);
endinterface

/* hdl/bawm_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bawm_out_if
// Result channel: found flag and error level of a window.
// ----------------------------------------------------------------------------
interface bawm_out_if import bawm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [COUNT_W-1:0] error_count;

  modport source (output valid, found, error_count, input ready);
  modport sink   (input valid, found, error_count, output ready);
endinterface

/* hdl/bawm_mask.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bawm_mask
// Builds the shift-and character mask of one text code against the pattern.
// ----------------------------------------------------------------------------
module bawm_mask import bawm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = DEF_MAX_PATTERN
) (
  input  logic [CODE_W-1:0]     code,
  input  logic [LEN_W-1:0]      len,
  input  logic [CODES_LO_W-1:0] codes_low,
  input  logic [CODES_HI_W-1:0] codes_high,
  output logic [MAX_PATTERN-1:0] mask
);

  localparam int unsigned LO_SYMS = CODES_LO_W / CODE_W;

  logic [MAX_PATTERN-1:0] pos_hit;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_pos
    logic [CODE_W-1:0] sym;
    if (j < LO_SYMS) begin : g_lo
      assign sym = codes_low[CODE_W*j +: CODE_W];
    end else begin : g_hi
      assign sym = codes_high[CODE_W*(j-LO_SYMS) +: CODE_W];
    end
    assign pos_hit[j] = (sym == code) && (LEN_W'(j) < len);
  end

  // N in the text matches every position
  assign mask = (code == ANY_CODE) ? '1 : pos_hit;

endmodule

/* hdl/bawm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bawm_cell
// One error level of the shift-and chain; holds that level's match vector.
// ----------------------------------------------------------------------------
module bawm_cell import bawm_pkg::*; #(
  parameter int unsigned VEC_W = DEF_MAX_PATTERN,
  parameter bit          BASE  = 1'b0
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  logic [VEC_W-1:0] mask,
  input  logic [VEC_W-1:0] tap_sel,
  input  logic [VEC_W-1:0] prev_old,
  input  logic [VEC_W-1:0] prev_new,
  output logic [VEC_W-1:0] old_vec,
  output logic [VEC_W-1:0] new_vec,
  output logic             hit
);

  logic [VEC_W-1:0] vec;
  logic [VEC_W-1:0] cur;
  logic [VEC_W-1:0] shifted;

  assign cur     = ctrl.restart ? VEC_W'(1) : vec;
  assign shifted = (cur << 1) | VEC_W'(1);
  assign old_vec = cur;

  if (BASE) begin : g_base
    assign new_vec = shifted & mask;
  end else begin : g_err
    // match, or substitution/insertion/deletion from the level below
    assign new_vec = (shifted & mask)
                   | (((prev_old | prev_new) << 1) | VEC_W'(1))
                   | prev_old;
  end

  assign hit = |(new_vec & tap_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      vec <= VEC_W'(1);
    end else if (ctrl.advance) begin
      vec <= new_vec;
    end
  end

endmodule

/* hdl/bawm_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bawm_out_buf
// Result register with a skid stage so the symbol side keeps flowing.
// ----------------------------------------------------------------------------
module bawm_out_buf import bawm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  result_t    push_data,
  output logic       space,
  bawm_out_if.source res_out
);

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign space = !skid_valid;
  assign pop   = out_valid && res_out.ready;

  assign res_out.valid       = out_valid;
  assign res_out.found       = out_data.found;
  assign res_out.error_count = out_data.error_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* hdl/approximate_bitap_window_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// approximate_bitap_window_matcher
// Windowed k-errors shift-and matcher over 4-bit nucleotide codes.
// ----------------------------------------------------------------------------
// Takes one symbol per clock cycle while sym_in.ready is high, and a window's
// result is registered when its deciding symbol is accepted. The MAX_ERRORS+1
// error levels are a row of cells, one match vector each; each cell hands its
// old and new vector to the next level, so a symbol updates all levels in the
// same cycle. Results go through an output register plus one skid entry; sym_in
// drops ready only when both hold results not yet taken by the sink.
// Configuration registers: 0 pattern codes 0-15, 1 pattern codes 16-30,
// 2 pattern length (0 never matches), 3 error limit. Write them while idle.
// ----------------------------------------------------------------------------
module approximate_bitap_window_matcher import bawm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int unsigned MAX_ERRORS  = DEF_MAX_ERRORS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bawm_in_if.sink               sym_in,
  bawm_out_if.source            res_out
);

  localparam int unsigned LEVELS = MAX_ERRORS + 1;
  localparam int unsigned ELIM_W = 4;

  logic [CODES_LO_W-1:0] codes_low;
  logic [CODES_HI_W-1:0] codes_high;
  logic [LEN_W-1:0]      pattern_length;
  logic [LIMIT_W-1:0]    error_limit;

  logic [SEEN_W-1:0] seen;
  logic [SEEN_W-1:0] seen_next;
  logic [SEEN_W-1:0] seen_base;
  logic              done;

  logic              accept;
  logic              space;
  logic              advance;
  cell_ctrl_t        ctrl;
  logic [LEN_W-1:0]  len;
  logic [ELIM_W-1:0] lim;
  logic [MAX_PATTERN-1:0] mask;
  logic [MAX_PATTERN-1:0] tap_sel;
  logic [MAX_PATTERN-1:0] old_v [LEVELS];
  logic [MAX_PATTERN-1:0] new_v [LEVELS];
  logic [LEVELS-1:0]      hit;

  logic    exact;
  logic    push;
  result_t res;
  logic    end_found;
  logic [COUNT_W-1:0] end_count;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      codes_low      <= '0;
      codes_high     <= '0;
      pattern_length <= '0;
      error_limit    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CODES_LOW:  codes_low      <= cfg_data[CODES_LO_W-1:0];
        REG_CODES_HIGH: codes_high     <= cfg_data[CODES_HI_W-1:0];
        REG_LENGTH:     pattern_length <= cfg_data[LEN_W-1:0];
        REG_ERR_LIMIT:  error_limit    <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign len = (pattern_length > LEN_W'(MAX_PATTERN)) ? '0 : pattern_length;
  assign lim = (ELIM_W'(error_limit) > ELIM_W'(MAX_ERRORS)) ? ELIM_W'(MAX_ERRORS)
             : ELIM_W'(error_limit);
  assign tap_sel = (len != '0) ? (MAX_PATTERN'(1) << (len - LEN_W'(1))) : '0;

  assign sym_in.ready = space;
  assign accept       = sym_in.valid && sym_in.ready;
  // a start reopens a finished window before the symbol is processed
  assign advance      = accept && (sym_in.window_start || !done);
  assign ctrl.restart = accept && sym_in.window_start;
  assign ctrl.advance = advance;

  bawm_mask #(.MAX_PATTERN(MAX_PATTERN)) u_mask (
    .code       (sym_in.base_code),
    .len        (len),
    .codes_low  (codes_low),
    .codes_high (codes_high),
    .mask       (mask)
  );

  for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
    logic [MAX_PATTERN-1:0] p_old;
    logic [MAX_PATTERN-1:0] p_new;
    if (k == 0) begin : g_first
      assign p_old = '0;
      assign p_new = '0;
    end else begin : g_link
      assign p_old = old_v[k-1];
      assign p_new = new_v[k-1];
    end
    bawm_cell #(.VEC_W(MAX_PATTERN), .BASE(k == 0)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .mask     (mask),
      .tap_sel  (tap_sel),
      .prev_old (p_old),
      .prev_new (p_new),
      .old_vec  (old_v[k]),
      .new_vec  (new_v[k]),
      .hit      (hit[k])
    );
  end

  assign seen_base = sym_in.window_start ? '0 : seen;
  assign seen_next = (seen_base < SEEN_MAX) ? seen_base + SEEN_W'(1) : seen_base;

  assign exact = (len != '0) && (seen_next == SEEN_W'(len)) && hit[0];

  // least error level from 1 up to the limit at window end
  always_comb begin
    end_found = 1'b0;
    end_count = '0;
    for (int k = 1; k <= MAX_ERRORS; k++) begin
      if (!end_found && hit[k] && (k <= int'(lim))) begin
        end_found = 1'b1;
        end_count = COUNT_W'(k);
      end
    end
    if (len == '0 || seen_next < SEEN_W'(len)) begin
      end_found = 1'b0;
      end_count = '0;
    end
  end

  assign push = advance && (exact || sym_in.window_end);
  assign res.found       = exact ? 1'b1 : end_found;
  assign res.error_count = exact ? '0 : end_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      done <= 1'b0;
    end else if (advance) begin
      seen <= seen_next;
      done <= exact || sym_in.window_end;
    end
  end

  bawm_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .space     (space),
    .res_out   (res_out)
  );

endmodule

/* dv/approximate_bitap_window_matcher_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// approximate_bitap_window_matcher_tb
// Self-checking bench for the windowed k-errors shift-and matcher. Symbol
// requests go in through the input channel, in bursts with random gaps, and
// the result channel stalls on its own random pattern. A scoreboard runs its
// own copy of the match vectors and registers and predicts the report of each
// window. Every result is checked in order against that prediction. The run
// covers a short directed section and then several register settings with
// random windows: clean windows, windows with edits, and noise.
// ----------------------------------------------------------------------------
module approximate_bitap_window_matcher_tb;
  import bawm_pkg::*;

  localparam int unsigned VEC_W        = DEF_MAX_PATTERN;
  localparam int unsigned LEVELS       = DEF_MAX_ERRORS + 1;
  localparam logic [VEC_W-1:0] VEC_ONE = 1;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_ITEMS  = 135;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned END_CYCLES   = 20;
  localparam int unsigned STALL_LIMIT  = 2000;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              first;
    logic              last;
  } symbol_req_t;

  // Predicts the report of each window from the accepted symbol requests.
  class bitap_window_scoreboard;
    logic [CODES_LO_W-1:0] codes_low;
    logic [CODES_HI_W-1:0] codes_high;
    logic [LEN_W-1:0]      pattern_len;
    logic [LIMIT_W-1:0]    error_limit;
    logic [VEC_W-1:0]      level_vec[LEVELS];
    logic [SEEN_W-1:0]     symbols_seen;
    bit                    window_done;
    result_t               expected_results[$];
    int unsigned           errors;

    function new();
      codes_low   = '0;
      codes_high  = '0;
      pattern_len = '0;
      error_limit = '0;
      errors      = 0;
      restart_window();
    endfunction

    function void restart_window();
      foreach (level_vec[k]) level_vec[k] = VEC_ONE;
      symbols_seen = '0;
      window_done  = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] reg_index, logic [CFG_DATA_W-1:0] data);
      case (reg_index)
        REG_CODES_LOW:  codes_low   = data[CODES_LO_W-1:0];
        REG_CODES_HIGH: codes_high  = data[CODES_HI_W-1:0];
        REG_LENGTH:     pattern_len = data[LEN_W-1:0];
        REG_ERR_LIMIT:  error_limit = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CODE_W-1:0] pattern_symbol(int unsigned j);
      if (j < 16) return codes_low[4*j +: 4];
      return codes_high[4*(j-16) +: 4];
    endfunction

    function void note_request(logic [CODE_W-1:0] code, logic first, logic last);
      logic [VEC_W-1:0] hit_mask;
      logic [VEC_W-1:0] old_below;
      logic [VEC_W-1:0] old_here;
      int unsigned      len;
      int unsigned      j;
      int unsigned      k;
      result_t          res;
      if (first) restart_window();
      if (window_done) return;
      len = pattern_len;
      hit_mask = '0;
      if (code == ANY_CODE) begin
        hit_mask = '1;
      end else begin
        for (j = 0; j < len; j++)
          if (pattern_symbol(j) == code) hit_mask[j] = 1'b1;
      end
      // old vector of the level below feeds substitution and deletion terms
      old_below = level_vec[0];
      level_vec[0] = ((level_vec[0] << 1) | VEC_ONE) & hit_mask;
      for (k = 1; k < LEVELS; k++) begin
        old_here = level_vec[k];
        level_vec[k] = (((level_vec[k] << 1) | VEC_ONE) & hit_mask)
                     | (((old_below | level_vec[k-1]) << 1) | VEC_ONE)
                     | old_below;
        old_below = old_here;
      end
      if (symbols_seen != SEEN_MAX) symbols_seen++;
      if (len != 0 && symbols_seen == len && level_vec[0][len-1]) begin
        window_done     = 1'b1;
        res.found       = 1'b1;
        res.error_count = '0;
        expected_results = {expected_results, res};
        return;
      end
      if (!last) return;
      window_done = 1'b1;
      res = '0;
      if (len != 0 && symbols_seen >= len) begin
        for (k = 1; k <= error_limit && !res.found; k++) begin
          if (level_vec[k][len-1]) begin
            res.found       = 1'b1;
            res.error_count = COUNT_W'(k);
          end
        end
      end
      expected_results = {expected_results, res};
    endfunction

    function void check_result(logic found, logic [COUNT_W-1:0] count);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: found=%0b error_count=%0d", found, count);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0b, got %0b", want.found, found);
        errors++;
      end
      if (count !== want.error_count) begin
        $error("error_count: expected %0d, got %0d", want.error_count, count);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bawm_in_if  sym_if ();
  bawm_out_if res_if ();

  approximate_bitap_window_matcher uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sym_in    (sym_if),
    .res_out   (res_if)
  );

  bitap_window_scoreboard sb = new();

  symbol_req_t       request_q[$];
  logic [CODE_W-1:0] pat_sym[DEF_MAX_PATTERN];
  int unsigned       cur_len;
  int unsigned       cur_limit;
  int unsigned       stall_pct;
  bit                long_hold_due;
  int unsigned       idle_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // monitor: results first, then the symbol request, then register writes
  always @(posedge clk) begin
    if (!rst) begin
      if (res_if.valid && res_if.ready)
        sb.check_result(res_if.found, res_if.error_count);
      if (sym_if.valid && sym_if.ready)
        sb.note_request(sym_if.base_code, sym_if.window_start, sym_if.window_end);
      if (cfg_write)
        sb.write_reg(cfg_index, cfg_data);
      if ((res_if.valid && res_if.ready) || (sym_if.valid && sym_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $error("no handshake for %0d cycles", STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result sink: random ready runs, plus one long hold-off when asked
  initial begin
    int unsigned run_left;
    logic        take;
    run_left     = 0;
    take         = 1'b1;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        run_left = 0;
      end
      if (run_left == 0) begin
        take     = ($urandom_range(0, 99) >= stall_pct);
        run_left = $urandom_range(1, 8);
      end
      res_if.ready <= take;
      run_left--;
    end
  end

  function automatic logic [CODE_W-1:0] pick_base();
    if ($urandom_range(0, 99) < 80) return CODE_W'($urandom_range(0, 3));
    return CODE_W'($urandom_range(0, 15));
  endfunction

  function automatic void push_req(logic [CODE_W-1:0] code, logic first, logic last);
    symbol_req_t req;
    req.code  = code;
    req.first = first;
    req.last  = last;
    request_q = {request_q, req};
  endfunction

  function automatic void add_noise();
    int unsigned n;
    n = $urandom_range(1, 5);
    repeat (n)
      push_req(CODE_W'($urandom_range(0, 15)), $urandom_range(0, 5) == 0,
               $urandom_range(0, 3) == 0);
  endfunction

  // One window, from the pattern with edits or random; returns its symbol count.
  function automatic int unsigned add_window();
    logic [CODE_W-1:0] txt[$];
    int unsigned       kind;
    int unsigned       edits;
    int unsigned       pos;
    int unsigned       i;
    logic              has_start;
    logic              has_end;
    kind = $urandom_range(0, 99);
    if (kind < 3) begin
      // long enough to saturate the symbol count when above 62 symbols
      repeat ($urandom_range(60, 75)) txt = {txt, pick_base()};
    end else if (cur_len == 0 || kind < 12) begin
      repeat ($urandom_range(1, 10)) txt = {txt, pick_base()};
    end else begin
      for (i = 0; i < cur_len; i++) txt = {txt, pat_sym[i]};
      edits = $urandom_range(0, cur_limit + 1);
      repeat (edits) begin
        pos = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 2))
          0: txt[pos] = pick_base();
          1: txt.insert(pos, pick_base());
          default: if (txt.size() > 1) txt.delete(pos);
        endcase
      end
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) txt.push_front(pick_base());
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) txt = {txt, pick_base()};
      foreach (txt[j])
        if ($urandom_range(0, 19) == 0) txt[j] = ANY_CODE;
    end
    has_start = ($urandom_range(0, 99) >= 8);
    has_end   = ($urandom_range(0, 99) >= 8);
    foreach (txt[j])
      push_req(txt[j], has_start && j == 0, has_end && j == txt.size() - 1);
    if ($urandom_range(0, 99) < 6)
      repeat ($urandom_range(1, 3)) push_req(pick_base(), 1'b0, $urandom_range(0, 1));
    return txt.size();
  endfunction

  function automatic void build_phase(int unsigned target);
    int unsigned count;
    count = 0;
    while (count < target) begin
      if ($urandom_range(0, 99) < 8) add_noise();
      else count += add_window();
    end
  endfunction

  function automatic void randomize_pattern();
    foreach (pat_sym[j]) pat_sym[j] = pick_base();
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] reg_index, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= reg_index;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic load_pattern(int unsigned len, int unsigned limit);
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    lo = '0;
    hi = '0;
    foreach (pat_sym[j]) begin
      if (j < 16) lo[4*j +: 4] = pat_sym[j];
      else        hi[4*(j-16) +: 4] = pat_sym[j];
    end
    write_reg(REG_CODES_LOW, lo);
    write_reg(REG_CODES_HIGH, hi);
    write_reg(REG_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_ERR_LIMIT, CFG_DATA_W'(limit));
    cfg_write <= 1'b0;
    cur_len   = len;
    cur_limit = limit;
  endtask

  task automatic drive_requests(int unsigned gap_max, int pause_at);
    symbol_req_t req;
    int unsigned burst_left;
    int          sent;
    burst_left = 0;
    sent       = 0;
    while (request_q.size() != 0) begin
      if (sent == pause_at) begin
        // hold the input until every pending result is out
        sym_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        @(negedge clk);
      end else if (gap_max != 0 && burst_left == 0) begin
        sym_if.valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
        burst_left = $urandom_range(1, 24);
      end
      req = request_q.pop_front();
      sym_if.valid        <= 1'b1;
      sym_if.base_code    <= req.code;
      sym_if.window_start <= req.first;
      sym_if.window_end   <= req.last;
      @(posedge clk);
      while (!sym_if.ready) @(posedge clk);
      @(negedge clk);
      sent++;
      if (burst_left != 0) burst_left--;
    end
    sym_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int unsigned phase;
    int unsigned len;
    int unsigned limit;
    int unsigned gap_max;
    int unsigned target;
    int unsigned r;
    int          pause_at;
    rst                 = 1'b1;
    cfg_write           = 1'b0;
    cfg_index           = REG_CODES_LOW;
    cfg_data            = '0;
    sym_if.valid        = 1'b0;
    sym_if.base_code    = '0;
    sym_if.window_start = 1'b0;
    sym_if.window_end   = 1'b0;
    stall_pct           = 0;
    long_hold_due       = 1'b0;
    idle_cycles         = 0;
    cur_len             = 0;
    cur_limit           = 0;
    foreach (pat_sym[j]) pat_sym[j] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // symbols before any start belong to the window opened by reset
    push_req(4'd0, 1'b0, 1'b0);
    push_req(ANY_CODE, 1'b0, 1'b1);
    drive_requests(0, -1);
    wait_drained();

    pat_sym[0] = 4'd1;
    pat_sym[1] = 4'd2;
    pat_sym[2] = 4'd3;
    pat_sym[3] = 4'd4;
    load_pattern(4, 2);
    // exact hit, then an end on a finished window that must be ignored
    push_req(4'd1, 1'b1, 1'b0);
    push_req(4'd2, 1'b0, 1'b0);
    push_req(4'd3, 1'b0, 1'b0);
    push_req(4'd4, 1'b0, 1'b0);
    push_req(4'd9, 1'b0, 1'b1);
    // N in the text
    push_req(4'd1, 1'b1, 1'b0);
    push_req(ANY_CODE, 1'b0, 1'b0);
    push_req(4'd3, 1'b0, 1'b0);
    push_req(4'd4, 1'b0, 1'b1);
    // one substitution
    push_req(4'd1, 1'b1, 1'b0);
    push_req(4'd2, 1'b0, 1'b0);
    push_req(4'd7, 1'b0, 1'b0);
    push_req(4'd4, 1'b0, 1'b1);
    // one deletion, window shorter than the pattern
    push_req(4'd1, 1'b1, 1'b0);
    push_req(4'd3, 1'b0, 1'b0);
    push_req(4'd4, 1'b0, 1'b1);
    // too many errors
    push_req(4'd5, 1'b1, 1'b0);
    push_req(4'd6, 1'b0, 1'b0);
    push_req(4'd7, 1'b0, 1'b0);
    push_req(4'd8, 1'b0, 1'b1);
    // start and end on the same symbol
    push_req(4'd2, 1'b1, 1'b1);
    drive_requests(0, -1);
    wait_drained();

    for (phase = 0; phase < PHASES; phase++) begin
      randomize_pattern();
      gap_max   = 0;
      stall_pct = 0;
      pause_at  = -1;
      target    = PHASE_ITEMS;
      case (phase)
        0: begin
          len   = DEF_MAX_PATTERN;
          limit = DEF_MAX_ERRORS;
        end
        1: begin
          len       = 1;
          limit     = 0;
          gap_max   = 30;
          stall_pct = 70;
        end
        2: begin
          // short windows fill the result buffer during the hold-off
          len   = 3;
          limit = 1;
        end
        3: begin
          len       = 0;
          limit     = DEF_MAX_ERRORS;
          target    = PHASE_ITEMS / 3;
          gap_max   = 4;
          stall_pct = 30;
        end
        4: begin
          len      = $urandom_range(4, 10);
          limit    = 3;
          pause_at = PHASE_ITEMS / 2;
          gap_max  = 4;
        end
        5: begin
          foreach (pat_sym[j]) pat_sym[j] = ANY_CODE;
          len       = 5;
          limit     = 2;
          stall_pct = 30;
        end
        default: begin
          r = $urandom_range(0, 9);
          if (r < 7)      len = $urandom_range(2, 10);
          else if (r < 9) len = $urandom_range(11, 30);
          else            len = ($urandom_range(0, 1) != 0) ? DEF_MAX_PATTERN : 1;
          limit = $urandom_range(0, DEF_MAX_ERRORS);
          case ($urandom_range(0, 2))
            0: gap_max = 0;
            1: gap_max = 4;
            default: gap_max = 30;
          endcase
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 30;
            default: stall_pct = 70;
          endcase
        end
      endcase
      load_pattern(len, limit);
      build_phase(target);
      if (phase == 2) long_hold_due = 1'b1;
      drive_requests(gap_max, pause_at);
      wait_drained();
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
